// ===== design/bhpq_pkg.sv =====
// Shared codes for the binary max-heap priority queue.
// No dependencies; imported by the queue's top level.
`timescale 1ns / 1ps

package bhpq_pkg;

    // Item kinds on the input channel.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RM_LOAD = 3'd1;
    localparam logic [2:0] ST_DN_CMP  = 3'd2;
    localparam logic [2:0] ST_UP_CMP  = 3'd3;
    localparam logic [2:0] ST_UP_WR   = 3'd4;
    localparam logic [2:0] ST_FINISH  = 3'd5;

endpackage

// ===== design/bhpq_mem.sv =====
// Heap slot storage: one write port and two registered read ports.
// No dependencies; instantiated by binary_max_heap_priority_queue.
`timescale 1ns / 1ps

module bhpq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] slots [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slots[waddr] <= wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        rdata_a <= slots[raddr_a];
        rdata_b <= slots[raddr_b];
    end

endmodule

// ===== design/binary_max_heap_priority_queue.sv =====
// Bounded binary max-heap priority queue of (priority, handle) entries.
// Depends on bhpq_pkg and bhpq_mem.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_stall   kind, prio, handle
//   result   res_valid / res_stall out_valid, out_handle, out_prio, dropped, count
//
// One item is in work at a time. An insert moves up L levels and a remove sifts down L
// levels (about log2 of DEPTH at most). The read of the next level overlaps this level's
// compare and write. Inserts into an empty or full heap and removes from an empty heap
// skip the sift steps. Reset clears the fill count and the handshake state; slot storage
// needs no clearing. A stalled result holds in the output register; the next item is
// taken meanwhile and its result waits in the final state until the register frees.
`timescale 1ns / 1ps

module binary_max_heap_priority_queue
    import bhpq_pkg::*;
#(
    parameter int DEPTH        = 16,
    parameter int PRIO_WIDTH   = 8,
    parameter int HANDLE_WIDTH = 8,
    localparam int CW          = $clog2(DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    kind,
    input  logic [PRIO_WIDTH-1:0]   prio,
    input  logic [HANDLE_WIDTH-1:0] handle,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic                    out_valid,
    output logic [HANDLE_WIDTH-1:0] out_handle,
    output logic [PRIO_WIDTH-1:0]   out_prio,
    output logic                    dropped,
    output logic [CW-1:0]           count
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = CW + 1;
    localparam int DW = PRIO_WIDTH + HANDLE_WIDTH;

    // Control registers.
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          res_valid_reg, res_valid_next;

    // Working payload registers.
    logic [DW-1:0]           mv_reg, mv_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [AW-1:0]           par_reg, par_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [HANDLE_WIDTH-1:0] pend_handle_reg, pend_handle_next;
    logic [PRIO_WIDTH-1:0]   pend_prio_reg, pend_prio_next;
    logic                    pend_drop_reg, pend_drop_next;
    logic [CW-1:0]           pend_count_reg, pend_count_next;

    // Output payload registers.
    logic                    ovalid_reg, ovalid_next;
    logic [HANDLE_WIDTH-1:0] ohandle_reg, ohandle_next;
    logic [PRIO_WIDTH-1:0]   oprio_reg, oprio_next;
    logic                    odrop_reg, odrop_next;
    logic [CW-1:0]           ocount_reg, ocount_next;

    // Memory ports.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr_a;
    logic [AW-1:0] mem_raddr_b;
    logic [DW-1:0] mem_rdata_a;
    logic [DW-1:0] mem_rdata_b;

    bhpq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // Sift-down compare: children of the hole, the winner, and the winner's children.
    logic [IW-1:0]         fill_w;
    logic [IW-1:0]         lc_w, rc_w;
    logic [PRIO_WIDTH-1:0] mv_prio, l_prio, r_prio, best_prio;
    logic                  l_ok, r_ok;
    logic [AW-1:0]         best_idx;
    logic [DW-1:0]         best_data;
    logic [IW-1:0]         nlc_w, nrc_w;
    logic [AW-1:0]         nlc_addr, nrc_addr;

    always_comb
    begin
        fill_w    = IW'(fill_reg);
        lc_w      = IW'({pos_reg, 1'b1});
        rc_w      = lc_w + IW'(1);
        mv_prio   = mv_reg[DW-1:HANDLE_WIDTH];
        l_prio    = mem_rdata_a[DW-1:HANDLE_WIDTH];
        r_prio    = mem_rdata_b[DW-1:HANDLE_WIDTH];
        l_ok      = (lc_w < fill_w) && (l_prio > mv_prio);
        best_prio = l_ok ? l_prio : mv_prio;
        r_ok      = (rc_w < fill_w) && (r_prio > best_prio);
        if (r_ok)
        begin
            best_idx  = rc_w[AW-1:0];
            best_data = mem_rdata_b;
        end
        else
        begin
            best_idx  = lc_w[AW-1:0];
            best_data = mem_rdata_a;
        end
        nlc_w    = IW'({best_idx, 1'b1});
        nrc_w    = nlc_w + IW'(1);
        nlc_addr = (nlc_w < fill_w) ? nlc_w[AW-1:0] : '0;
        nrc_addr = (nrc_w < fill_w) ? nrc_w[AW-1:0] : '0;
    end

    // Sequencer: item decode, sift steps and result hand-off.
    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        res_valid_next   = res_valid_reg;
        mv_next          = mv_reg;
        pos_next         = pos_reg;
        par_next         = par_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        pend_prio_next   = pend_prio_reg;
        pend_drop_next   = pend_drop_reg;
        pend_count_next  = pend_count_reg;
        ovalid_next      = ovalid_reg;
        ohandle_next     = ohandle_reg;
        oprio_next       = oprio_reg;
        odrop_next       = odrop_reg;
        ocount_next      = ocount_reg;
        mem_we           = 1'b0;
        mem_waddr        = pos_reg;
        mem_wdata        = mv_reg;
        mem_raddr_a      = '0;
        mem_raddr_b      = '0;

        // A taken result frees the output register.
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pend_valid_next  = 1'b0;
                    pend_handle_next = '0;
                    pend_prio_next   = '0;
                    pend_drop_next   = 1'b0;
                    if (kind == KIND_INSERT)
                    begin
                        if (fill_reg == CW'(DEPTH))
                        begin
                            pend_drop_next  = 1'b1;
                            pend_count_next = fill_reg;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            fill_next       = fill_reg + CW'(1);
                            pend_count_next = fill_reg + CW'(1);
                            mv_next         = {prio, handle};
                            pos_next        = fill_reg[AW-1:0];
                            if (fill_reg == '0)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = {prio, handle};
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                par_next    = (fill_reg[AW-1:0] - AW'(1)) >> 1;
                                mem_raddr_a = par_next;
                                state_next  = ST_UP_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (fill_reg == '0)
                        begin
                            pend_count_next = '0;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            mem_raddr_a = '0;
                            mem_raddr_b = AW'(fill_reg - CW'(1));
                            fill_next   = fill_reg - CW'(1);
                            state_next  = ST_RM_LOAD;
                        end
                    end
                end
            end

            // Root is the result; the last entry becomes the hole's occupant.
            ST_RM_LOAD:
            begin
                pend_valid_next  = 1'b1;
                pend_prio_next   = mem_rdata_a[DW-1:HANDLE_WIDTH];
                pend_handle_next = mem_rdata_a[HANDLE_WIDTH-1:0];
                pend_count_next  = fill_reg;
                mv_next          = mem_rdata_b;
                pos_next         = '0;
                if (fill_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    mem_raddr_a = (CW'(1) < fill_reg) ? AW'(1) : '0;
                    mem_raddr_b = (CW'(2) < fill_reg) ? AW'(2) : '0;
                    state_next  = ST_DN_CMP;
                end
            end

            // One level of sift-down: promote the winning child or settle.
            ST_DN_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                if (l_ok || r_ok)
                begin
                    mem_wdata   = best_data;
                    pos_next    = best_idx;
                    mem_raddr_a = nlc_addr;
                    mem_raddr_b = nrc_addr;
                end
                else
                begin
                    mem_wdata  = mv_reg;
                    state_next = ST_FINISH;
                end
            end

            // One level of sift-up: pull the parent down or settle.
            ST_UP_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                if (mem_rdata_a[DW-1:HANDLE_WIDTH] < mv_prio)
                begin
                    mem_wdata = mem_rdata_a;
                    pos_next  = par_reg;
                    if (par_reg == '0)
                    begin
                        state_next = ST_UP_WR;
                    end
                    else
                    begin
                        par_next    = (par_reg - AW'(1)) >> 1;
                        mem_raddr_a = par_next;
                    end
                end
                else
                begin
                    mem_wdata  = mv_reg;
                    state_next = ST_FINISH;
                end
            end

            // The new entry reached the root.
            ST_UP_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = mv_reg;
                state_next = ST_FINISH;
            end

            // Move the result into the output register once it is free.
            ST_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    ovalid_next    = pend_valid_reg;
                    ohandle_next   = pend_handle_reg;
                    oprio_next     = pend_prio_reg;
                    odrop_next     = pend_drop_reg;
                    ocount_next    = pend_count_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mv_reg          <= mv_next;
        pos_reg         <= pos_next;
        par_reg         <= par_next;
        pend_valid_reg  <= pend_valid_next;
        pend_handle_reg <= pend_handle_next;
        pend_prio_reg   <= pend_prio_next;
        pend_drop_reg   <= pend_drop_next;
        pend_count_reg  <= pend_count_next;
        ovalid_reg      <= ovalid_next;
        ohandle_reg     <= ohandle_next;
        oprio_reg       <= oprio_next;
        odrop_reg       <= odrop_next;
        ocount_reg      <= ocount_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign res_valid  = res_valid_reg;
    assign out_valid  = ovalid_reg;
    assign out_handle = ohandle_reg;
    assign out_prio   = oprio_reg;
    assign dropped    = odrop_reg;
    assign count      = ocount_reg;

    // The fill count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= CW'(DEPTH))
        else $error("fill count above capacity");

    // Every slot write lands inside the region occupied after this cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CW'(mem_waddr) < fill_next))
        else $error("slot write beyond fill");

    // The sift-down hole always sits on an occupied slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DN_CMP) |-> (CW'(pos_reg) < fill_reg))
        else $error("sift-down position beyond fill");

    // A dropped insert reports a full heap and returns no entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && dropped) |-> (count == CW'(DEPTH) && !out_valid))
        else $error("dropped result inconsistent");

    // A returned entry leaves at least one free slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid) |-> (count < CW'(DEPTH)))
        else $error("removal result count inconsistent");

endmodule

// ===== dv/heap_queue_checker.sv =====
// Scoreboard for the binary max-heap priority queue: predicts each result and compares it.
// Depends on bhpq_pkg for the item kind codes; watches both channels of the queue.
`timescale 1ns / 1ps

module heap_queue_checker
    import bhpq_pkg::*;
#(
    parameter int DEPTH        = 16,
    parameter int PRIO_WIDTH   = 8,
    parameter int HANDLE_WIDTH = 8,
    localparam int CW          = $clog2(DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    kind,
    input  logic [PRIO_WIDTH-1:0]   prio,
    input  logic [HANDLE_WIDTH-1:0] handle,
    input  logic                    res_valid,
    input  logic                    res_stall,
    input  logic                    out_valid,
    input  logic [HANDLE_WIDTH-1:0] out_handle,
    input  logic [PRIO_WIDTH-1:0]   out_prio,
    input  logic                    dropped,
    input  logic [CW-1:0]           count,
    output int                      pending,
    output int                      errors
);

    typedef struct packed {
        logic [PRIO_WIDTH-1:0]   prio;
        logic [HANDLE_WIDTH-1:0] handle;
    } heap_entry_t;

    typedef struct packed {
        logic                    present;
        logic [HANDLE_WIDTH-1:0] handle;
        logic [PRIO_WIDTH-1:0]   prio;
        logic                    refused;
        logic [CW-1:0]           held;
    } heap_result_t;

    // Shadow copy of the heap as the queue should hold it.
    heap_entry_t  shadow_heap [DEPTH];
    int           shadow_fill;
    heap_result_t awaited_results [$];
    int           mismatch_count = 0;

    assign errors = mismatch_count;

    // One line per problem, and one count.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void swap_entries(input int a, input int b);
        heap_entry_t tmp;
        tmp            = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = tmp;
    endfunction

    // Applies one item to the shadow heap and returns the result it must produce.
    function automatic heap_result_t serve_item(input logic k,
                                                input logic [PRIO_WIDTH-1:0] p,
                                                input logic [HANDLE_WIDTH-1:0] h);
        heap_result_t r;
        int pos;
        int parent;
        int pick;
        int left;
        int right;
        r = '0;
        if (k == KIND_INSERT) begin
            if (shadow_fill >= DEPTH) begin
                r.refused = 1'b1;
            end
            else begin
                pos = shadow_fill;
                shadow_heap[pos].prio   = p;
                shadow_heap[pos].handle = h;
                shadow_fill++;
                // Climb while the parent is strictly lower.
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (shadow_heap[parent].prio >= shadow_heap[pos].prio)
                        break;
                    swap_entries(parent, pos);
                    pos = parent;
                end
            end
        end
        else if (shadow_fill > 0) begin
            r.present = 1'b1;
            r.handle  = shadow_heap[0].handle;
            r.prio    = shadow_heap[0].prio;
            shadow_fill--;
            shadow_heap[0] = shadow_heap[shadow_fill];
            pos = 0;
            // Sink the moved entry; the right child wins only when strictly above the left.
            while (pos < shadow_fill) begin
                pick  = pos;
                left  = 2 * pos + 1;
                right = 2 * pos + 2;
                if (left < shadow_fill && shadow_heap[left].prio > shadow_heap[pick].prio)
                    pick = left;
                if (right < shadow_fill && shadow_heap[right].prio > shadow_heap[pick].prio)
                    pick = right;
                if (pick == pos)
                    break;
                swap_entries(pos, pick);
                pos = pick;
            end
        end
        r.held = CW'(shadow_fill);
        return r;
    endfunction

    // Results are checked before the input of the same edge is taken, since no item
    // can finish in the cycle of its own transfer.
    always @(posedge clk or negedge rst_n) begin
        heap_result_t want;
        if (!rst_n) begin
            shadow_fill = 0;
            awaited_results.delete();
        end
        else begin
            if (res_valid && !res_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result transfer with no item outstanding");
                end
                else begin
                    want = awaited_results.pop_front();
                    if (out_valid !== want.present)
                        report_mismatch($sformatf("out_valid: expected %0d, got %0d",
                                                  want.present, out_valid));
                    if (out_handle !== want.handle)
                        report_mismatch($sformatf("out_handle: expected %0d, got %0d",
                                                  want.handle, out_handle));
                    if (out_prio !== want.prio)
                        report_mismatch($sformatf("out_prio: expected %0d, got %0d",
                                                  want.prio, out_prio));
                    if (dropped !== want.refused)
                        report_mismatch($sformatf("dropped: expected %0d, got %0d",
                                                  want.refused, dropped));
                    if (count !== want.held)
                        report_mismatch($sformatf("count: expected %0d, got %0d",
                                                  want.held, count));
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(serve_item(kind, prio, handle));
        end
        pending = awaited_results.size();
    end

endmodule

// ===== dv/binary_max_heap_priority_queue_test.sv =====
// Top of the priority queue testbench: clock, reset, stimulus and the final verdict.
// Depends on bhpq_pkg, the queue itself and heap_queue_checker.
`timescale 1ns / 1ps

module binary_max_heap_priority_queue_test;
    import bhpq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int PRIO_WIDTH   = 8;
    localparam int HANDLE_WIDTH = 8;
    localparam int CW           = $clog2(DEPTH + 1);
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 250;
    localparam int PHASE_ITEMS  = 231;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    kind;
    logic [PRIO_WIDTH-1:0]   prio;
    logic [HANDLE_WIDTH-1:0] handle;
    logic                    res_valid;
    logic                    res_stall = 1'b0;
    logic                    out_valid;
    logic [HANDLE_WIDTH-1:0] out_handle;
    logic [PRIO_WIDTH-1:0]   out_prio;
    logic                    dropped;
    logic [CW-1:0]           count;

    int pending;
    int errors;
    int idle_pct    = 0;
    int stall_pct   = 0;
    bit hold_armed  = 1'b0;
    int hold_count  = 0;
    int cycle_count = 0;

    binary_max_heap_priority_queue #(
        .DEPTH       (DEPTH),
        .PRIO_WIDTH  (PRIO_WIDTH),
        .HANDLE_WIDTH(HANDLE_WIDTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .prio      (prio),
        .handle    (handle),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_valid (out_valid),
        .out_handle(out_handle),
        .out_prio  (out_prio),
        .dropped   (dropped),
        .count     (count)
    );

    heap_queue_checker #(
        .DEPTH       (DEPTH),
        .PRIO_WIDTH  (PRIO_WIDTH),
        .HANDLE_WIDTH(HANDLE_WIDTH)
    ) u_heap_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .prio      (prio),
        .handle    (handle),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_valid (out_valid),
        .out_handle(out_handle),
        .out_prio  (out_prio),
        .dropped   (dropped),
        .count     (count),
        .pending   (pending),
        .errors    (errors)
    );

    always #6 clk = ~clk;

    // Run guard against a hung handshake.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: one long hold-off when armed, random stalls otherwise.
    always @(negedge clk) begin
        if (hold_armed && hold_count < HOLD_CYCLES) begin
            res_stall <= 1'b1;
            hold_count++;
        end
        else begin
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offers one item, called at a falling edge and returning at one. The valid line is
    // lowered only for a gap, so back-to-back items keep it high.
    task automatic send_item(input logic k, input logic [PRIO_WIDTH-1:0] p,
                             input logic [HANDLE_WIDTH-1:0] h);
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < idle_pct)
                @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        prio     <= p;
        handle   <= h;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Priorities lean toward ties and extremes so the tie rules get exercised.
    function automatic logic [PRIO_WIDTH-1:0] pick_prio();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45)
            return PRIO_WIDTH'($urandom_range(3));
        else if (sel < 60)
            return ($urandom_range(1) != 0) ? '1 : '0;
        else
            return PRIO_WIDTH'($urandom());
    endfunction

    initial begin
        logic [PRIO_WIDTH-1:0] seed_prios [16];
        int sent;
        int burst;
        int insert_bias;
        logic k;

        seed_prios = '{8'd255, 8'd0, 8'd7, 8'd7, 8'd7, 8'd128, 8'd255, 8'd0,
                       8'd1, 8'd254, 8'd7, 8'd3, 8'd7, 8'd64, 8'd200, 8'd7};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_INSERT;
        prio      = '0;
        handle    = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: remove from empty, fill with ties and extremes, insert into a full
        // heap, then drain part of it.
        send_item(KIND_REMOVE, '1, '1);
        for (int i = 0; i < DEPTH; i++)
            send_item(KIND_INSERT, seed_prios[i],
                      (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : HANDLE_WIDTH'(i * 17));
        send_item(KIND_INSERT, 8'd99, 8'h5A);
        repeat (7)
            send_item(KIND_REMOVE, '0, '0);

        // Random phases, each with its own idle and stall pattern. Bursts swing the heap
        // between full and empty.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  hold_armed = 1'b1; end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(10, 40);
                case ($urandom_range(2))
                    0: insert_bias = 85;
                    1: insert_bias = 50;
                    default: insert_bias = 15;
                endcase
                for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
                    k = ($urandom_range(99) < insert_bias) ? KIND_INSERT : KIND_REMOVE;
                    send_item(k, pick_prio(), HANDLE_WIDTH'($urandom()));
                    sent++;
                end
            end
        end
        in_valid <= 1'b0;

        // Drain, then keep watching for anything stray.
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
